// File: hdl/tsrs_pkg.sv
`timescale 1ns / 1ps

package tsrs_pkg;

    // Packet geometry
    localparam int unsigned PACKET_BYTES = 188;
    localparam logic [7:0]  POS_MAX      = 8'hff;
    localparam logic [7:0]  OFFSET_TABLE_ID = 8'h73;

    // Configuration register indexes
    localparam int unsigned CFG_INDEX_BITS = 2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_TIME_PID    = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_TIME_OFFSET = 2'd1;

    localparam logic [12:0] TIME_PID_RESET    = 13'd20;
    localparam logic [32:0] TIME_OFFSET_RESET = 33'd0;

    // Command queue between classifier and output side
    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);

    // Time conversion constants.
    // The bias makes the sampled time positive: 49711 days, 9124 days past
    // the MJD epoch offset. Reset value maps to MJD 0 at midnight.
    localparam logic [33:0] TIME_BIAS   = 34'd4295030400;
    localparam logic [33:0] TIME_RESET  = 34'd788313600;
    localparam logic [15:0] MJD_ADJUST  = 16'd9124;
    localparam logic [27:0] RECIP_675   = 28'd203613264; // floor(2^37 / 675)
    localparam logic [10:0] RECIP_3600  = 11'd1165;      // floor(2^22 / 3600)
    localparam logic [10:0] RECIP_60    = 11'd1092;      // floor(2^16 / 60)

    localparam logic [31:0] CRC_INIT = 32'hffff_ffff;
    localparam logic [31:0] CRC_POLY = 32'h04c1_1db7;

    typedef struct packed {
        logic [7:0] data;       // outgoing byte, time already substituted
        logic       overrun;    // section runs past the packet end
        logic       crc_init;   // restart CRC before feeding this byte
        logic       crc_feed;   // feed this byte into the CRC
        logic       crc_sel;    // replace this byte by a CRC byte
        logic [1:0] crc_idx;    // which CRC byte, 3 = most significant
    } t_cmd;

    typedef struct packed {
        logic [15:0] mjd;
        logic [23:0] bcd;       // hour in [23:16]
    } t_stamp;

    // Two BCD digits of a value below 64
    function automatic logic [7:0] to_bcd(input logic [5:0] v);
        logic [13:0] prod;
        logic [3:0]  tens;
        logic [5:0]  ones;
        prod = {8'b0, v} * 14'd205;
        tens = prod[14-1:11] > 3'd0 ? {1'b0, prod[13:11]} : 4'd0;
        ones = v - ({2'b0, tens} * 6'd10);
        return {tens, ones[3:0]};
    endfunction

    // MSB-first CRC-32/MPEG-2 update over one byte
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {b, 24'b0};
        for (int k = 0; k < 8; k++) begin
            c = c[31] ? ({c[30:0], 1'b0} ^ CRC_POLY) : {c[30:0], 1'b0};
        end
        return c;
    endfunction

endpackage

// File: hdl/ts_time_table_restamper_core.sv
`timescale 1ns / 1ps
// Channel | Dir | Handshake                 | Fields
// --------+-----+---------------------------+-------------------------------------------
// stream  | in  | push / full, push & !full | i_data_byte, i_packet_first, i_utc_seconds
// result  | out | empty / pop, pop & !empty | o_out_byte, o_section_overrun
// config  | in  | i_cfg_valid & o_cfg_ready | i_cfg_index, i_cfg_data
//
// One byte per cycle sustained while the consumer keeps popping. A taken request is written
// into the command queue, then loads the output register once the output side takes it
// from the queue, which a pop stall can delay.
// A packet start launches a seven-stage time conversion; its MJD and BCD values are
// picked up by the classifier when byte 8 arrives, at least eight requests later.
// Reset is synchronous and active low; it restores time_pid 20, time_offset 0 and an
// all-ones CRC. No clearing pass is needed.
// full rises only when the four-entry command queue is full; pop stalls hold the
// output register while the classifier keeps taking requests.

module ts_time_table_restamper_core (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   push,
    output logic                                   full,
    input  logic [7:0]                             i_data_byte,
    input  logic                                   i_packet_first,
    input  logic [31:0]                            i_utc_seconds,
    output logic                                   empty,
    input  logic                                   pop,
    output logic [7:0]                             o_out_byte,
    output logic                                   o_section_overrun,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [tsrs_pkg::CFG_INDEX_BITS-1:0]    i_cfg_index,
    input  logic [32:0]                            i_cfg_data
);
    import tsrs_pkg::*;

    // Configuration registers
    logic [12:0] r_time_pid,    n_time_pid;
    logic [32:0] r_time_offset, n_time_offset;

    logic   accept;
    logic   start;
    t_stamp stamp;
    t_cmd   front_cmd;
    t_cmd   queue_cmd;
    logic   queue_empty;
    logic   back_take;

    // Configuration is always ready; writes beyond the register list are dropped
    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_time_pid    = r_time_pid;
        n_time_offset = r_time_offset;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_TIME_PID:    n_time_pid    = i_cfg_data[12:0];
                CFG_TIME_OFFSET: n_time_offset = i_cfg_data;
                default:         ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time_pid    <= TIME_PID_RESET;
            r_time_offset <= TIME_OFFSET_RESET;
        end else begin
            r_time_pid    <= n_time_pid;
            r_time_offset <= n_time_offset;
        end
    end

    // Take a request whenever the command queue has room
    assign accept = push && !full;
    // Sample the time on every packet mark
    assign start  = accept && i_packet_first;

    tsrs_time u_time (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_utc_seconds (i_utc_seconds),
        .i_time_offset (r_time_offset),
        .o_stamp       (stamp)
    );

    // Classify each byte: position, PID match, table id, section length,
    // time substitution and CRC actions
    tsrs_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_data_byte    (i_data_byte),
        .i_packet_first (i_packet_first),
        .i_time_pid     (r_time_pid),
        .i_stamp        (stamp),
        .o_cmd          (front_cmd)
    );

    // Decouple classifier from the CRC and output side
    tsrs_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_cmd   (front_cmd),
        .o_full  (full),
        .i_pop   (back_take),
        .o_cmd   (queue_cmd),
        .o_empty (queue_empty)
    );

    // Run the CRC in stream order and hold the result for the consumer
    tsrs_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (!queue_empty),
        .i_cmd             (queue_cmd),
        .o_take            (back_take),
        .o_empty           (empty),
        .i_pop             (pop),
        .o_out_byte        (o_out_byte),
        .o_section_overrun (o_section_overrun)
    );

    a_no_take_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        back_take |-> !queue_empty)
        else $error("output side took from an empty queue");
    a_full_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        full && !back_take |=> full)
        else $error("queue drained without a take");
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_out_byte) && $stable(o_section_overrun))
        else $error("stalled result changed");

endmodule

// File: hdl/tsrs_time.sv
`timescale 1ns / 1ps

module tsrs_time (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [31:0]        i_utc_seconds,
    input  logic [32:0]        i_time_offset,
    output tsrs_pkg::t_stamp   o_stamp
);
    import tsrs_pkg::*;

    // Biased time, held from one packet start to the next
    logic [33:0] r_u;
    logic [33:0] n_u;

    // Free-running conversion stages fed from r_u
    logic [17:0] r_qest;
    logic [10:0] r_rem1;
    logic [17:0] r_qest2;
    logic [16:0] r_sod;
    logic [15:0] r_mjd;
    logic [5:0]  r_hest;
    logic [4:0]  r_hour;
    logic [11:0] r_s2;
    logic [5:0]  r_mest;
    logic [4:0]  r_hour2;
    logic [11:0] r_s2b;
    logic [23:0] r_bcd;

    logic [54:0] prod_day;
    logic [27:0] prod_chk;
    logic [27:0] rem_day_w;
    logic        day_up;
    logic [17:0] days;
    logic [9:0]  day_rem;
    logic [27:0] prod_h;
    logic [16:0] chk_h;
    logic [12:0] rem_h;
    logic        h_up;
    logic [21:0] prod_m;
    logic [11:0] chk_m;
    logic [6:0]  rem_m;
    logic        m_up;
    logic [5:0]  minute;
    logic [5:0]  second;

    always_comb begin
        n_u = r_u;
        if (i_start) begin
            n_u = {2'b0, i_utc_seconds} + {i_time_offset[32], i_time_offset} + TIME_BIAS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_u <= TIME_RESET;
        end else begin
            r_u <= n_u;
        end
    end

    // Days: u / 86400 = (u >> 7) / 675
    assign prod_day  = {28'b0, r_u[33:7]} * {27'b0, RECIP_675};
    assign prod_chk  = {10'b0, r_qest} * 28'd675;
    assign rem_day_w = {1'b0, r_u[33:7]} - prod_chk;
    assign day_up    = r_rem1 >= 11'd675;
    assign days      = r_qest2 + {17'b0, day_up};
    assign day_rem   = day_up ? 10'(r_rem1 - 11'd675) : r_rem1[9:0];

    // Hours and minutes by reciprocal estimate plus one correction
    assign prod_h = {11'b0, r_sod} * {17'b0, RECIP_3600};
    assign chk_h  = {11'b0, r_hest} * 17'd3600;
    assign rem_h  = 13'(r_sod - chk_h);
    assign h_up   = rem_h >= 13'd3600;
    assign prod_m = {10'b0, r_s2} * {11'b0, RECIP_60};
    assign chk_m  = {6'b0, r_mest} * 12'd60;
    assign rem_m  = 7'(r_s2b - chk_m);
    assign m_up   = rem_m >= 7'd60;
    assign minute = r_mest + {5'b0, m_up};
    assign second = m_up ? 6'(rem_m - 7'd60) : rem_m[5:0];

    always_ff @(posedge i_clk) begin
        r_qest  <= prod_day[54:37];
        r_rem1  <= rem_day_w[10:0];
        r_qest2 <= r_qest;
        r_sod   <= {day_rem, r_u[6:0]};
        r_mjd   <= days[15:0] - MJD_ADJUST;
        r_hest  <= prod_h[27:22];
        r_hour  <= 5'(r_hest + {5'b0, h_up});
        r_s2    <= h_up ? 12'(rem_h - 13'd3600) : rem_h[11:0];
        r_mest  <= prod_m[21:16];
        r_hour2 <= r_hour;
        r_s2b   <= r_s2;
        r_bcd   <= {to_bcd({1'b0, r_hour2}), to_bcd(minute), to_bcd(second)};
    end

    assign o_stamp.mjd = r_mjd;
    assign o_stamp.bcd = r_bcd;

    a_sod_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past($stable(r_u), 1) && $past($stable(r_u), 2) |-> r_sod < 17'd86400)
        else $error("seconds of day out of range");
    a_hour_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past($stable(r_u), 2) && $past($stable(r_u), 3) && $past($stable(r_u), 4)
        |-> r_hour < 5'd24 && r_s2 < 12'd3600)
        else $error("hour split out of range");
    a_min_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past($stable(r_u), 3) && $past($stable(r_u), 4) && $past($stable(r_u), 5)
        |-> minute < 6'd60 && second < 6'd60)
        else $error("minute split out of range");

endmodule

// File: hdl/tsrs_front.sv
`timescale 1ns / 1ps

module tsrs_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  logic [7:0]         i_data_byte,
    input  logic               i_packet_first,
    input  logic [12:0]        i_time_pid,
    input  tsrs_pkg::t_stamp   i_stamp,
    output tsrs_pkg::t_cmd     o_cmd
);
    import tsrs_pkg::*;

    localparam logic [12:0] PB = 13'(PACKET_BYTES);

    logic [7:0]  r_pos,    n_pos;
    logic [4:0]  r_pid_hi, n_pid_hi;
    logic        r_is_time, n_is_time;
    logic        r_is_tot,  n_is_tot;
    logic [11:0] r_len,    n_len;

    logic [7:0]  pos;
    logic [12:0] pos13;
    logic [12:0] len13;
    logic        overrun;
    logic        crc_ok;
    logic [12:0] idx13;

    always_comb begin
        pos       = i_packet_first ? 8'd0 : r_pos;
        pos13     = {5'b0, pos};
        n_pos     = (pos < POS_MAX) ? pos + 8'd1 : POS_MAX;
        n_pid_hi  = r_pid_hi;
        n_is_time = i_packet_first ? 1'b0 : r_is_time;
        n_is_tot  = i_packet_first ? 1'b0 : r_is_tot;
        n_len     = r_len;
        len13     = {1'b0, r_len};
        overrun   = 1'b0;
        crc_ok    = 1'b0;
        idx13     = 13'd0;
        o_cmd          = '0;
        o_cmd.data     = i_data_byte;

        if (pos13 < PB) begin
            if (pos == 8'd1) begin
                n_pid_hi = i_data_byte[4:0];
            end else if (pos == 8'd2) begin
                n_is_time = ({r_pid_hi, i_data_byte} == i_time_pid);
            end else if (n_is_time) begin
                if (pos == 8'd5) begin
                    n_is_tot       = (i_data_byte == OFFSET_TABLE_ID);
                    o_cmd.crc_init = 1'b1;
                end else if (pos == 8'd6) begin
                    n_len = {i_data_byte[3:0], 8'h00};
                end else if (pos == 8'd7) begin
                    n_len = r_len | {4'b0, i_data_byte};
                end
                len13 = {1'b0, n_len};

                // Substitute MJD and BCD time
                if (pos == 8'd8) begin
                    o_cmd.data = i_stamp.mjd[15:8];
                end else if (pos == 8'd9) begin
                    o_cmd.data = i_stamp.mjd[7:0];
                end else if (pos == 8'd10) begin
                    o_cmd.data = i_stamp.bcd[23:16];
                end else if (pos == 8'd11) begin
                    o_cmd.data = i_stamp.bcd[15:8];
                end else if (pos == 8'd12) begin
                    o_cmd.data = i_stamp.bcd[7:0];
                end

                overrun = n_is_tot && (len13 + 13'd7 >= PB);
                crc_ok  = n_is_tot && (len13 >= 13'd4) && !overrun;
                o_cmd.crc_feed = n_is_tot && (pos >= 8'd5) &&
                                 ((pos <= 8'd7) || (pos13 <= len13 + 13'd3));
                o_cmd.crc_sel  = crc_ok && (pos >= 8'd8) &&
                                 (pos13 >= len13 + 13'd4) && (pos13 <= len13 + 13'd7);
                idx13          = len13 + 13'd7 - pos13;
                o_cmd.crc_idx  = idx13[1:0];
                o_cmd.overrun  = overrun && (pos >= 8'd7);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_pid_hi  <= '0;
            r_is_time <= 1'b0;
            r_is_tot  <= 1'b0;
            r_len     <= '0;
        end else if (i_accept) begin
            r_pos     <= n_pos;
            r_pid_hi  <= n_pid_hi;
            r_is_time <= n_is_time;
            r_is_tot  <= n_is_tot;
            r_len     <= n_len;
        end
    end

    a_sel_no_feed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && o_cmd.crc_sel |-> !o_cmd.crc_feed && !o_cmd.overrun)
        else $error("CRC byte also fed or flagged");
    a_tot_needs_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_is_tot |-> r_is_time)
        else $error("offset table outside time packet");
    a_pos_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && !i_packet_first && r_pos < POS_MAX |=> r_pos == $past(r_pos) + 8'd1)
        else $error("byte position did not advance");

endmodule

// File: hdl/tsrs_fifo.sv
`timescale 1ns / 1ps

module tsrs_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  tsrs_pkg::t_cmd   i_cmd,
    output logic             o_full,
    input  logic             i_pop,
    output tsrs_pkg::t_cmd   o_cmd,
    output logic             o_empty
);
    import tsrs_pkg::*;

    t_cmd                  r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr, n_wr;
    logic [FIFO_PTR_W-1:0] r_rd, n_rd;
    logic [FIFO_PTR_W:0]   r_count, n_count;
    logic                  do_push;
    logic                  do_pop;

    assign o_full  = (r_count == (FIFO_PTR_W + 1)'(FIFO_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_cmd   = r_mem[r_rd];

    always_comb begin
        n_wr    = do_push ? FIFO_PTR_W'(r_wr + 1'b1) : r_wr;
        n_rd    = do_pop  ? FIFO_PTR_W'(r_rd + 1'b1) : r_rd;
        n_count = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (FIFO_PTR_W + 1)'(FIFO_DEPTH))
        else $error("queue count beyond depth");
    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_push && !do_pop |=> r_count == $past(r_count) + 1'b1)
        else $error("queue count did not grow");
    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        FIFO_PTR_W'(r_wr - r_rd) == r_count[FIFO_PTR_W-1:0])
        else $error("queue pointers disagree with count");

endmodule

// File: hdl/tsrs_back.sv
`timescale 1ns / 1ps

module tsrs_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  tsrs_pkg::t_cmd   i_cmd,
    output logic             o_take,
    output logic             o_empty,
    input  logic             i_pop,
    output logic [7:0]       o_out_byte,
    output logic             o_section_overrun
);
    import tsrs_pkg::*;

    logic [31:0] r_crc, n_crc;
    logic        r_out_valid, n_out_valid;
    logic [7:0]  r_out_byte;
    logic        r_out_flag;
    logic [31:0] crc_base;
    logic [7:0]  crc_out;
    logic [7:0]  out_byte;

    assign o_take   = i_valid && (!r_out_valid || i_pop);
    assign crc_base = i_cmd.crc_init ? CRC_INIT : r_crc;

    always_comb begin
        unique case (i_cmd.crc_idx)
            2'd3:    crc_out = r_crc[31:24];
            2'd2:    crc_out = r_crc[23:16];
            2'd1:    crc_out = r_crc[15:8];
            default: crc_out = r_crc[7:0];
        endcase
        out_byte    = i_cmd.crc_sel ? crc_out : i_cmd.data;
        n_crc       = r_crc;
        n_out_valid = r_out_valid;
        if (o_take) begin
            n_out_valid = 1'b1;
            if (i_cmd.crc_feed) begin
                n_crc = crc_byte(crc_base, i_cmd.data);
            end else if (i_cmd.crc_init) begin
                n_crc = CRC_INIT;
            end
        end else if (i_pop) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc       <= CRC_INIT;
            r_out_valid <= 1'b0;
        end else begin
            r_crc       <= n_crc;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_out_byte <= out_byte;
            r_out_flag <= i_cmd.overrun;
        end
    end

    assign o_empty           = !r_out_valid;
    assign o_out_byte        = r_out_byte;
    assign o_section_overrun = r_out_flag;

    a_take_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_take |=> r_out_valid)
        else $error("taken command left no result");
    a_hold_crc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_take |=> r_crc == $past(r_crc))
        else $error("CRC moved without a command");
    a_sel_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_cmd.crc_sel |-> !i_cmd.crc_feed && !i_cmd.crc_init)
        else $error("CRC output command also updates CRC");

endmodule

// File: sim/ts_restamp_checker.sv
`timescale 1ns / 1ps

module ts_restamp_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  logic        i_full,
    input  logic [7:0]  i_data_byte,
    input  logic        i_packet_first,
    input  logic [31:0] i_utc_seconds,
    input  logic        i_empty,
    input  logic        i_pop,
    input  logic [7:0]  i_out_byte,
    input  logic        i_section_overrun,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [tsrs_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [32:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);

    import tsrs_pkg::*;

    localparam longint SECS_PER_DAY = 86400;
    localparam longint MJD_EPOCH    = 40587;
    localparam logic [31:0] CRC_SEED = 32'hffff_ffff;
    localparam logic [31:0] CRC_GEN  = 32'h04c1_1db7;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       overrun;
    } t_out_byte;

    t_out_byte   out_byte_q[$];

    // Predictor state and register copies
    logic [12:0] cfg_pid;
    longint      cfg_offset;
    int unsigned stream_pos;
    logic [4:0]  pid_hi;
    logic        in_time_pid;
    logic        in_tot;
    logic [11:0] sec_len;
    logic [31:0] crc;
    logic [15:0] stamp_mjd;
    logic [23:0] stamp_bcd;

    function automatic logic [7:0] bcd2(input int unsigned v);
        return {4'(v / 10), 4'(v % 10)};
    endfunction

    function automatic logic [31:0] crc_step(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] r;
        r = c ^ {b, 24'h0};
        for (int k = 0; k < 8; k++) begin
            r = r[31] ? ({r[30:0], 1'b0} ^ CRC_GEN) : {r[30:0], 1'b0};
        end
        return r;
    endfunction

    // Floor the shifted time to whole days; the MJD wraps at 16 bits
    task automatic sample_stamp(input logic [31:0] utc);
        longint      t;
        longint      days;
        longint      rem;
        int unsigned sod;
        t = utc;
        t = t + cfg_offset;
        days = t / SECS_PER_DAY;
        rem  = t % SECS_PER_DAY;
        if (rem < 0) begin
            rem  = rem + SECS_PER_DAY;
            days = days - 1;
        end
        sod = int'(rem);
        stamp_mjd = 16'(days + MJD_EPOCH);
        stamp_bcd = {bcd2(sod / 3600), bcd2((sod / 60) % 60), bcd2(sod % 60)};
    endtask

    task automatic restamp_byte(input logic [7:0] b, input logic first, input logic [31:0] utc,
                                output t_out_byte res);
        int unsigned pos;
        int unsigned len;
        logic        overrun;
        logic        crc_ok;
        pos = first ? 0 : stream_pos;
        res.out_byte = b;
        res.overrun  = 1'b0;
        if (first) begin
            sample_stamp(utc);
            in_time_pid = 1'b0;
            in_tot      = 1'b0;
        end
        if (pos < PACKET_BYTES) begin
            if (pos == 1) begin
                pid_hi = b[4:0];
            end else if (pos == 2) begin
                in_time_pid = ({pid_hi, b} == cfg_pid);
            end else if (in_time_pid) begin
                if (pos == 5) begin
                    in_tot = (b == OFFSET_TABLE_ID);
                    crc    = CRC_SEED;
                end else if (pos == 6) begin
                    sec_len = {b[3:0], 8'h00};
                end else if (pos == 7) begin
                    sec_len = sec_len | {4'h0, b};
                end
                len = sec_len;
                if (pos == 8 || pos == 9) begin
                    res.out_byte = 8'(stamp_mjd >> (8 * (9 - pos)));
                end else if (pos >= 10 && pos <= 12) begin
                    res.out_byte = 8'(stamp_bcd >> (8 * (12 - pos)));
                end
                overrun = in_tot && (len + 7 >= PACKET_BYTES);
                crc_ok  = in_tot && len >= 4 && !overrun;
                if (in_tot && pos >= 5 && (pos <= 7 || pos <= len + 3)) begin
                    crc = crc_step(crc, res.out_byte);
                end
                if (crc_ok && pos >= 8 && pos >= len + 4 && pos <= len + 7) begin
                    res.out_byte = 8'(crc >> (8 * (len + 7 - pos)));
                end
                if (overrun && pos >= 7) begin
                    res.overrun = 1'b1;
                end
            end
        end
        stream_pos = (pos < 255) ? pos + 1 : 255;
    endtask

    always @(posedge i_clk) begin
        t_out_byte want;
        t_out_byte next_out;
        if (!i_rst_n) begin
            cfg_pid     = TIME_PID_RESET;
            cfg_offset  = 0;
            stream_pos  = 0;
            pid_hi      = '0;
            in_time_pid = 1'b0;
            in_tot      = 1'b0;
            sec_len     = '0;
            crc         = CRC_SEED;
            stamp_mjd   = '0;
            stamp_bcd   = '0;
            out_byte_q.delete();
            o_fail_count = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_TIME_PID: begin
                        cfg_pid = i_cfg_data[12:0];
                    end
                    CFG_TIME_OFFSET: begin
                        cfg_offset = $signed(i_cfg_data);
                    end
                    default: begin
                    end
                endcase
            end
            // Results leave before the request taken at this edge can show up
            if (i_pop && !i_empty) begin
                if (out_byte_q.size() == 0) begin
                    $error("result %02h/%0b with nothing outstanding",
                           i_out_byte, i_section_overrun);
                    o_fail_count++;
                end else begin
                    want = out_byte_q.pop_front();
                    if (i_out_byte !== want.out_byte) begin
                        $error("out_byte: expected %02h, actual %02h",
                               want.out_byte, i_out_byte);
                        o_fail_count++;
                    end
                    if (i_section_overrun !== want.overrun) begin
                        $error("section_overrun: expected %0b, actual %0b",
                               want.overrun, i_section_overrun);
                        o_fail_count++;
                    end
                end
            end
            if (i_push && !i_full) begin
                restamp_byte(i_data_byte, i_packet_first, i_utc_seconds, next_out);
                out_byte_q.push_back(next_out);
            end
        end
        o_pending = out_byte_q.size();
    end

endmodule

// File: sim/ts_time_table_restamper_core_tb.sv
`timescale 1ns / 1ps

module ts_time_table_restamper_core_tb;

    import tsrs_pkg::*;

    localparam int ITEMS_PER_PHASE = 40;

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    logic [7:0]  i_data_byte;
    logic        i_packet_first;
    logic [31:0] i_utc_seconds;
    logic        empty;
    logic        pop;
    logic [7:0]  o_out_byte;
    logic        o_section_overrun;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [CFG_INDEX_BITS-1:0] i_cfg_index;
    logic [32:0] i_cfg_data;

    int          fail_count;
    int          pending;

    // Stimulus bookkeeping
    bit          calm;
    logic [12:0] cur_pid;
    int          n_bytes;
    int          n_sections;
    int          n_settings;

    ts_time_table_restamper_core u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .push              (push),
        .full              (full),
        .i_data_byte       (i_data_byte),
        .i_packet_first    (i_packet_first),
        .i_utc_seconds     (i_utc_seconds),
        .empty             (empty),
        .pop               (pop),
        .o_out_byte        (o_out_byte),
        .o_section_overrun (o_section_overrun),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    ts_restamp_checker u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_push            (push),
        .i_full            (full),
        .i_data_byte       (i_data_byte),
        .i_packet_first    (i_packet_first),
        .i_utc_seconds     (i_utc_seconds),
        .i_empty           (empty),
        .i_pop             (pop),
        .i_out_byte        (o_out_byte),
        .i_section_overrun (o_section_overrun),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .o_fail_count      (fail_count),
        .o_pending         (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Hard stop: far beyond the slowest legal run with every stall at its longest
    initial begin
        #3_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // Result side: drain with random stall bursts, none once the run goes calm
    initial begin
        int stall_left;
        stall_left = 0;
        pop = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                pop = 1'b0;
                stall_left--;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                pop = 1'b0;
                stall_left = $urandom_range(1, 18) - 1;
            end else begin
                pop = 1'b1;
            end
        end
    end

    // Drive one stream request, maybe after an idle burst; hold it until taken
    task automatic send_byte(input logic [7:0] b, input logic f, input logic [31:0] u);
        int gap;
        if (!calm && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 18);
            push = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        push           = 1'b1;
        i_data_byte    = b;
        i_packet_first = f;
        i_utc_seconds  = u;
        do @(posedge i_clk); while (full);
        @(negedge i_clk);
        n_bytes++;
    endtask

    // Pick a time: mostly random, sometimes the range ends or a midnight edge
    function automatic logic [31:0] pick_utc();
        case ($urandom_range(0, 9))
            0:       return 32'h0000_0000;
            1:       return 32'hffff_ffff;
            2:       return 32'(86400 * $urandom_range(0, 49000) + $urandom_range(0, 1)
                            - $urandom_range(0, 1));
            default: return $urandom;
        endcase
    endfunction

    // Build a section header: PID in bytes 1..2, table id in 5, length in 6..7;
    // cut it at nbytes, which may stop short or run past the packet end
    task automatic send_section(input logic [12:0] pid, input logic [7:0] tid,
                                input logic [11:0] len, input int nbytes,
                                input bit marked, input logic [31:0] utc);
        logic [7:0] b;
        for (int pos = 0; pos < nbytes; pos++) begin
            case (pos)
                0:       b = $urandom_range(0, 1) ? 8'h47 : 8'($urandom);
                1:       b = {3'($urandom), pid[12:8]};
                2:       b = pid[7:0];
                5:       b = tid;
                6:       b = {4'($urandom), len[11:8]};
                7:       b = len[7:0];
                default: b = 8'($urandom);
            endcase
            send_byte(b, marked && pos == 0, pos == 0 ? utc : $urandom);
        end
        n_sections++;
    endtask

    // Garbage with stray packet marks
    task automatic send_noise();
        int nbytes;
        nbytes = $urandom_range(1, 20);
        repeat (nbytes) begin
            send_byte(8'($urandom), $urandom_range(0, 5) == 0, $urandom);
        end
    endtask

    task automatic send_random_packet();
        logic [12:0] pid;
        logic [7:0]  tid;
        logic [11:0] len;
        int          nbytes;
        if ($urandom_range(0, 99) < 12) begin
            send_noise();
        end else begin
            pid = ($urandom_range(0, 9) < 7) ? cur_pid : 13'($urandom);
            tid = ($urandom_range(0, 3) != 0) ? OFFSET_TABLE_ID : 8'($urandom);
            case ($urandom_range(0, 9))
                0, 1, 2, 3: len = 12'($urandom_range(4, 12));     // CRC lands on or covers time bytes
                4, 5:       len = 12'($urandom_range(0, 3));      // too short for a CRC
                6, 7:       len = 12'($urandom_range(13, 40));
                8:          len = 12'($urandom_range(177, 186));  // around the overrun edge
                default:    len = 12'($urandom_range(187, 4095));
            endcase
            if (len > 40) begin
                nbytes = $urandom_range(8, 24);
            end else begin
                nbytes = len + 8 + $urandom_range(0, 3);
            end
            // Cut some sections short, and run a few to the full packet length
            case ($urandom_range(0, 19))
                0, 1:    nbytes = $urandom_range(1, 12);
                2:       nbytes = PACKET_BYTES;
                default: begin
                end
            endcase
            send_section(pid, tid, len, nbytes, $urandom_range(0, 19) != 0, pick_utc());
        end
    endtask

    task automatic random_phase(input int quota);
        int start;
        start = n_bytes;
        while (n_bytes - start < quota) send_random_packet();
    endtask

    // Hold the sender until every outstanding result has come back
    task automatic drain();
        push = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_INDEX_BITS-1:0] idx, input logic [32:0] data);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
    endtask

    task automatic apply_setting(input logic [12:0] pid, input logic [32:0] offset);
        cfg_write(CFG_TIME_PID, {20'h0, pid});
        cfg_write(CFG_TIME_OFFSET, offset);
        i_cfg_valid = 1'b0;
        cur_pid = pid;
        n_settings++;
    endtask

    initial begin
        calm           = 1'b0;
        cur_pid        = TIME_PID_RESET;
        n_bytes        = 0;
        n_sections     = 0;
        n_settings     = 1;
        i_rst_n        = 1'b0;
        push           = 1'b0;
        i_data_byte    = '0;
        i_packet_first = 1'b0;
        i_utc_seconds  = '0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = CFG_TIME_PID;
        i_cfg_data     = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Start without a packet mark: the reset stamp gets used, CRC lands on time bytes
        send_section(TIME_PID_RESET, OFFSET_TABLE_ID, 12'd4, 13, 1'b0, 32'h0);
        // Marked packet at the top of the time range with a section too short for CRC
        send_section(TIME_PID_RESET, OFFSET_TABLE_ID, 12'd2, 12, 1'b1, 32'hffff_ffff);
        random_phase(ITEMS_PER_PHASE);

        // Highest PID, most negative offset: every time goes negative
        drain();
        apply_setting(13'h1fff, 33'h1_0000_0000);
        random_phase(ITEMS_PER_PHASE);

        // Lowest PID, largest offset; run one packet far past its end to saturate
        drain();
        apply_setting(13'h0000, 33'h0_ffff_ffff);
        send_section(cur_pid, OFFSET_TABLE_ID, 12'd6, 270, 1'b1, pick_utc());
        random_phase(ITEMS_PER_PHASE);

        drain();
        apply_setting(13'($urandom), 33'({$urandom_range(0, 1), $urandom}));
        random_phase(ITEMS_PER_PHASE);

        // Back to the reset PID with a small offset, full rate on both sides
        drain();
        apply_setting(TIME_PID_RESET, 33'(longint'($urandom_range(0, 1728000)) - 864000));
        calm = 1'b1;
        random_phase(ITEMS_PER_PHASE);

        push = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("Ran %0d stream bytes in %0d sections over %0d PID/offset settings,",
                 n_bytes, n_sections, n_settings);
        $display("with stamped, CRC, short, overrun, unmarked and past-end packets.");
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
